/* src/idct_pkg.sv */
// Shared types and constants for the 8x8 integer inverse DCT.
package idct_pkg;
  localparam int K1 = 2841;
  localparam int K2 = 2676;
  localparam int K3 = 2408;
  localparam int K5 = 1609;
  localparam int K6 = 1108;
  localparam int K7 = 565;
  localparam int KR = 181;
  localparam int ColBias = 8192;

  typedef logic signed [15:0] coef_t;
  typedef logic [7:0] pixel_t;
endpackage

/* src/idct_if.sv */
// Valid/ready channel interfaces for coefficients and pixels.
interface idct_coef_if;
  import idct_pkg::*;
  logic valid;
  logic ready;
  coef_t coefficient;
  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

interface idct_pix_if;
  import idct_pkg::*;
  logic valid;
  logic ready;
  pixel_t pixel;
  logic [2:0] row;
  logic [2:0] column;
  logic last_of_block;
  modport source (output valid, output pixel, output row, output column,
                  output last_of_block, input ready);
  modport sink (input valid, input pixel, input row, input column,
                input last_of_block, output ready);
endinterface

/* src/idct_8x8_integer.sv */
// Top level of the 8x8 integer inverse DCT with level shift and clamp.
//
// in:  one signed 16-bit coefficient per transaction, row-major order.
// out: 64 pixels per block, column by column, top to bottom, with row,
//      column and last_of_block tags.
// Coefficients load into a 64-entry memory, one per cycle. After the 64th
// the block stops taking input and runs both passes through the same memory:
// for each of the 8 rows, then each of the 8 columns, it reads 8 entries
// through the registered read port, computes the 1-D transform in S_CALC
// and writes back the 8 results (row pass) or emits them as pixels, one per
// accepted transaction (column pass). The block takes no coefficients of
// the next block until the column pass has registered its last pixel. The
// first pixel is registered after the whole row pass and the first column's
// reads and calculation. A stalled receiver holds the pixel register and
// stops the sequencer in its write state. Reset clears the load count and
// sequencer; the memory holds no reset value and every entry is written
// before it is read.
module idct_8x8_integer import idct_pkg::*; (
  input logic clk,
  input logic rst,
  idct_coef_if.sink in,
  idct_pix_if.source out
);
  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;

  coef_t mem [64];
  coef_t rd_data;
  logic [5:0] rd_addr;
  logic [2:0] state;
  logic [5:0] load_count;
  logic col_pass;
  logic [2:0] line;
  logic [3:0] idx;
  logic [1:0] calc_step;
  logic signed [15:0] src [8];
  logic signed [31:0] res [8];
  logic [7:0] pix_q;
  logic out_valid;
  logic [2:0] out_row, out_col;
  logic out_last;

  // pass arithmetic registers
  logic signed [31:0] b0, b1, b4, b5, b6, b7, b2, b3;
  logic signed [31:0] c1, c4, c6, c5, c7, ct, c3, c0;
  logic signed [31:0] d2, d4;

  logic accept_in;
  assign accept_in = (state == S_LOAD) && in.valid;
  assign in.ready = (state == S_LOAD);

  // address of element k of the current line
  function automatic logic [5:0] addr_of(input logic cp, input logic [2:0] ln,
                                         input logic [2:0] k);
    return cp ? {k, ln} : {ln, k};
  endfunction

  assign rd_addr = addr_of(col_pass, line, idx[2:0]);

  always_ff @(posedge clk) begin
    if (accept_in) mem[load_count] <= in.coefficient;
    else if (state == S_WRITE && !col_pass)
      mem[addr_of(1'b0, line, idx[2:0])] <= res[idx[2:0]][15:0];
    rd_data <= mem[rd_addr];
  end

  function automatic logic signed [31:0] shf(input logic signed [31:0] v,
                                             input logic cp);
    return cp ? (v >>> 3) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (state == S_READ && idx != 4'd0) src[idx[2:0] - 3'd1] <= rd_data;
    if (state == S_CALC) begin
      case (calc_step)
        2'd0: begin
          b0 <= col_pass ? (32'(src[0]) * 256 + ColBias) : (32'(src[0]) * 2048 + 128);
          b1 <= col_pass ? 32'(src[4]) * 256 : 32'(src[4]) * 2048;
          b4 <= shf(K7 * (32'(src[1]) + 32'(src[7])) + (col_pass ? 4 : 0)
                    + (K1 - K7) * 32'(src[1]), col_pass);
          b5 <= shf(K7 * (32'(src[1]) + 32'(src[7])) + (col_pass ? 4 : 0)
                    - (K1 + K7) * 32'(src[7]), col_pass);
          b6 <= shf(K3 * (32'(src[5]) + 32'(src[3])) + (col_pass ? 4 : 0)
                    - (K3 - K5) * 32'(src[5]), col_pass);
          b7 <= shf(K3 * (32'(src[5]) + 32'(src[3])) + (col_pass ? 4 : 0)
                    - (K3 + K5) * 32'(src[3]), col_pass);
          b2 <= shf(K6 * (32'(src[2]) + 32'(src[6])) + (col_pass ? 4 : 0)
                    - (K2 + K6) * 32'(src[6]), col_pass);
          b3 <= shf(K6 * (32'(src[2]) + 32'(src[6])) + (col_pass ? 4 : 0)
                    + (K2 - K6) * 32'(src[2]), col_pass);
        end
        2'd1: begin
          c1 <= b4 + b6;
          c4 <= b4 - b6;
          c6 <= b5 + b7;
          c5 <= b5 - b7;
          c7 <= b0 + b1 + b3;
          ct <= b0 + b1 - b3;
          c3 <= b0 - b1 + b2;
          c0 <= b0 - b1 - b2;
        end
        2'd2: begin
          // the product outgrows 32 bits in the row pass
          d2 <= 32'((KR * (48'(c4) + 48'(c5)) + 128) >>> 8);
          d4 <= 32'((KR * (48'(c4) - 48'(c5)) + 128) >>> 8);
        end
        default: begin
          res[0] <= (c7 + c1) >>> (col_pass ? 14 : 8);
          res[1] <= (c3 + d2) >>> (col_pass ? 14 : 8);
          res[2] <= (c0 + d4) >>> (col_pass ? 14 : 8);
          res[3] <= (ct + c6) >>> (col_pass ? 14 : 8);
          res[4] <= (ct - c6) >>> (col_pass ? 14 : 8);
          res[5] <= (c0 - d4) >>> (col_pass ? 14 : 8);
          res[6] <= (c3 - d2) >>> (col_pass ? 14 : 8);
          res[7] <= (c7 - c1) >>> (col_pass ? 14 : 8);
        end
      endcase
    end
  end

  logic signed [31:0] shifted;
  logic [7:0] clamped;
  assign shifted = res[idx[2:0]] + 32'sd128;
  always_comb begin
    if (shifted < 0) clamped = 8'd0;
    else if (shifted > 255) clamped = 8'd255;
    else clamped = shifted[7:0];
  end

  logic can_emit;
  assign can_emit = !out_valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      load_count <= '0;
      col_pass <= 1'b0;
      line <= '0;
      idx <= '0;
      calc_step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out.ready && !(state == S_WRITE && col_pass)) out_valid <= 1'b0;
      case (state)
        S_LOAD: if (accept_in) begin
          load_count <= load_count + 6'd1;
          if (load_count == 6'd63) begin
            state <= S_READ;
            col_pass <= 1'b0;
            line <= '0;
            idx <= '0;
          end
        end
        S_READ: begin
          // read data of index idx-1 lands this cycle
          if (idx == 4'd8) begin
            idx <= '0;
            calc_step <= '0;
            state <= S_CALC;
          end else idx <= idx + 4'd1;
        end
        S_CALC: begin
          calc_step <= calc_step + 2'd1;
          if (calc_step == 2'd3) state <= S_WRITE;
        end
        S_WRITE: begin
          if (!col_pass || can_emit) begin
            if (col_pass) begin
              out_valid <= 1'b1;
              pix_q <= clamped;
              out_row <= idx[2:0];
              out_col <= line;
              out_last <= (line == 3'd7) && (idx == 4'd7);
            end
            if (idx == 4'd7) begin
              idx <= '0;
              line <= line + 3'd1;
              if (line == 3'd7) begin
                if (col_pass) state <= S_LOAD;
                else begin
                  col_pass <= 1'b1;
                  state <= S_READ;
                end
              end else state <= S_READ;
            end else idx <= idx + 4'd1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign out.valid = out_valid;
  assign out.pixel = pix_q;
  assign out.row = out_row;
  assign out.column = out_col;
  assign out.last_of_block = out_last;

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_LOAD |-> !in.ready) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |=> out_valid && $stable(pix_q))
    else $error("pixel dropped under stall");
  a_emit_colpass: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(col_pass)) else $error("emit in row pass");
  a_count: assert property (@(posedge clk) disable iff (rst)
    state != S_LOAD |-> load_count == 6'd0) else $error("load count off");
endmodule

/* sim/tb.sv */
// Self-checking testbench for the 8x8 integer inverse DCT with level shift and clamp.
module tb;
  import idct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    pixel_t pixel;
    logic [2:0] row;
    logic [2:0] column;
    logic last_of_block;
  } pix_item_t;

  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  idct_coef_if in_ch ();
  idct_pix_if out_ch ();

  idct_8x8_integer dut (.clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source));

  coef_t pending_coefs[$];
  pix_item_t expected_pixels[$];
  coef_t block_coefs[64];
  int load_index = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_send = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint wrap_to_16(longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return longint'(w);
  endfunction

  // One 1-D Chen-Wang pass; is_col selects the column scaling and rounding.
  function automatic void idct_1d(input longint s[8], output longint d[8], input bit is_col);
    longint x0, x1, x2, x3, x4, x5, x6, x7, t, pre, rnd, fin;
    int sh;
    pre = is_col ? 256 : 2048;
    rnd = is_col ? 4 : 0;
    sh = is_col ? 3 : 0;
    fin = is_col ? 14 : 8;
    x0 = s[0] * pre + (is_col ? ColBias : 128);
    x1 = s[4] * pre;
    x2 = s[6]; x3 = s[2]; x4 = s[1]; x5 = s[7]; x6 = s[5]; x7 = s[3];
    t = K7 * (x4 + x5) + rnd;
    x4 = floor_shr(t + (K1 - K7) * x4, sh);
    x5 = floor_shr(t - (K1 + K7) * x5, sh);
    t = K3 * (x6 + x7) + rnd;
    x6 = floor_shr(t - (K3 - K5) * x6, sh);
    x7 = floor_shr(t - (K3 + K5) * x7, sh);
    t = x0 + x1;
    x0 -= x1;
    x1 = K6 * (x3 + x2) + rnd;
    x2 = floor_shr(x1 - (K2 + K6) * x2, sh);
    x3 = floor_shr(x1 + (K2 - K6) * x3, sh);
    x1 = x4 + x6;
    x4 -= x6;
    x6 = x5 + x7;
    x5 -= x7;
    x7 = t + x3;
    t -= x3;
    x3 = x0 + x2;
    x0 -= x2;
    x2 = floor_shr(KR * (x4 + x5) + 128, 8);
    x4 = floor_shr(KR * (x4 - x5) + 128, 8);
    d[0] = floor_shr(x7 + x1, fin);
    d[1] = floor_shr(x3 + x2, fin);
    d[2] = floor_shr(x0 + x4, fin);
    d[3] = floor_shr(t + x6, fin);
    d[4] = floor_shr(t - x6, fin);
    d[5] = floor_shr(x0 - x4, fin);
    d[6] = floor_shr(x3 - x2, fin);
    d[7] = floor_shr(x7 - x1, fin);
  endfunction

  // Transform a complete block and queue its 64 pixels in output order.
  task automatic predict_block();
    longint work[64];
    longint src[8];
    longint dst[8];
    longint v;
    pix_item_t p;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) src[c] = longint'(block_coefs[r * 8 + c]);
      idct_1d(src, dst, 1'b0);
      for (int c = 0; c < 8; c++) work[r * 8 + c] = wrap_to_16(dst[c]);
    end
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) src[r] = work[r * 8 + c];
      idct_1d(src, dst, 1'b1);
      for (int r = 0; r < 8; r++) begin
        v = dst[r] + 128;
        v = v < 0 ? 0 : (v > 255 ? 255 : v);
        p.pixel = pixel_t'(v);
        p.row = r[2:0];
        p.column = c[2:0];
        p.last_of_block = (c == 7 && r == 7);
        expected_pixels.push_back(p);
      end
    end
  endtask

  // Driver: present the next queued coefficient, advance on a transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.coefficient <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        block_coefs[load_index] = in_ch.coefficient;
        load_index = (load_index + 1) % 64;
        if (load_index == 0) predict_block();
        void'(pending_coefs.pop_front());
      end
      if (pending_coefs.size() != 0 && !hold_send &&
          (in_ch.valid && !in_ch.ready || $urandom_range(99) >= send_idle_pct)) begin
        in_ch.valid <= 1'b1;
        in_ch.coefficient <= pending_coefs[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each pixel transaction with the oldest expectation.
  always @(posedge clk) begin
    pix_item_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pixel, out_ch.row, out_ch.column, out_ch.last_of_block};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel %p", $time, got);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[idct_8x8_integer] ERROR");
        $finish;
      end
    end
  end

  task automatic add_block(int kind);
    coef_t v;
    for (int i = 0; i < 64; i++) begin
      case (kind)
        0: v = 16'sh7fff;
        1: v = 16'sh8000;
        2: v = (i == 0) ? coef_t'($urandom) : '0;
        3: v = ((i / 8) % 2) ? 16'sh7fff : 16'sh8000;
        4: v = coef_t'($urandom);
        default: begin
          // Typical dequantized content: big DC, small sparse AC.
          if (i == 0) v = coef_t'($urandom_range(4095)) - 16'sd2048;
          else if ($urandom_range(3) == 0) v = coef_t'($urandom_range(511)) - 16'sd256;
          else v = '0;
        end
      endcase
      pending_coefs.push_back(v);
    end
  endtask

  task automatic drain();
    while (pending_coefs.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 6;
    recv_idle_pct = 88;
    // Alternating extreme rows.
    add_block(3);
    // Wait until every pixel is out before sending more.
    drain();

    send_idle_pct = 88;
    recv_idle_pct = 6;
    hold_send = 1'b1;
    add_block(4);
    repeat (40) @(posedge clk);
    hold_send = 1'b0;
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_block(5);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) $display("[idct_8x8_integer] OK");
    else $display("[idct_8x8_integer] ERROR");
    $finish;
  end
endmodule
